[hw/rtl/swlr_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// swlr_pkg
// Shared constants and types for the sliding window loss rate block.
// ----------------------------------------------------------------------------
package swlr_pkg;

  // outcomes kept in the window
  localparam int WINDOW     = 32;
  localparam int SLOT_W     = (WINDOW > 1) ? $clog2(WINDOW) : 1;
  localparam int CNT_W      = $clog2(WINDOW + 1);

  // fixed field widths of the stream payload
  localparam int RTT_W      = 12;
  localparam int LOSS_W     = 15;
  localparam int CNT_OUT_W  = 6;
  localparam int S_DATA_W   = 16;
  localparam int M_DATA_W   = 40;

  // 100 percent in q8
  localparam int LOSS_SCALE = 25600;

  // divider operand widths: quotient never exceeds LOSS_SCALE
  localparam int NUM_W      = CNT_W + LOSS_W;
  localparam int STEP_W     = $clog2(NUM_W + 1);

  // input command codes
  localparam logic FUNC_RECORD = 1'b0;
  localparam logic FUNC_CLEAR  = 1'b1;

  // divider status seen by the sequencer
  typedef struct packed {
    logic busy;
    logic done;
  } div_status_t;

  // sequencer states
  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_LOAD = 4'b0010,
    S_DIV  = 4'b0100,
    S_HOLD = 4'b1000
  } seq_state_t;

endpackage
`default_nettype wire

[hw/rtl/swlr_window.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// swlr_window
// Outcome ring, write slot, sample and failure counts and latest good RTT.
// ----------------------------------------------------------------------------
module swlr_window
  import swlr_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             accept,
  input  wire logic             func,
  input  wire logic             probe_ok,
  input  wire logic [RTT_W-1:0] rtt_ms,
  output logic      [CNT_W-1:0] samples,
  output logic      [CNT_W-1:0] fails,
  output logic      [RTT_W-1:0] latest_rtt
);

  logic [WINDOW-1:0] ring;
  logic [SLOT_W-1:0] slot;
  logic [SLOT_W-1:0] slot_next;
  logic [CNT_W-1:0]  fails_next;
  logic              full;

  // window full once samples reach the window size
  assign full = (samples == CNT_W'(WINDOW));

  // slot advance with wrap
  assign slot_next = (slot == SLOT_W'(WINDOW - 1)) ? '0 : slot + 1'b1;

  // leaving outcome out, new outcome in
  always_comb begin
    fails_next = fails;
    if (full && !ring[slot] && (fails != '0)) begin
      fails_next = fails_next - 1'b1;
    end
    if (!probe_ok) begin
      fails_next = fails_next + 1'b1;
    end
  end

  // ring storage, no reset
  always_ff @(posedge clk) begin
    if (accept && (func == FUNC_RECORD)) begin
      ring[slot] <= probe_ok;
    end
  end

  // counters and rtt
  always_ff @(posedge clk) begin
    if (rst) begin
      slot       <= '0;
      samples    <= '0;
      fails      <= '0;
      latest_rtt <= '0;
    end else if (accept) begin
      if (func == FUNC_CLEAR) begin
        slot    <= '0;
        samples <= '0;
        fails   <= '0;
      end else begin
        slot  <= slot_next;
        fails <= fails_next;
        if (!full) begin
          samples <= samples + 1'b1;
        end
        if (probe_ok) begin
          latest_rtt <= rtt_ms;
        end
      end
    end
  end

endmodule
`default_nettype wire

[hw/rtl/swlr_div.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// swlr_div
// Restoring divider, one quotient bit per cycle through a shared subtractor.
// ----------------------------------------------------------------------------
module swlr_div
  import swlr_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             start,
  input  wire logic [NUM_W-1:0] dividend,
  input  wire logic [CNT_W-1:0] divisor,
  output div_status_t           status,
  output logic      [NUM_W-1:0] quotient
);

  logic [CNT_W-1:0]  rem;
  logic [CNT_W-1:0]  dvs;
  logic [STEP_W-1:0] step;
  logic [CNT_W:0]    trial;
  logic [CNT_W:0]    diff;
  logic              take;

  // shared compare and subtract
  assign trial = {rem, quotient[NUM_W-1]};
  assign diff  = trial - {1'b0, dvs};
  assign take  = (trial >= {1'b0, dvs});

  // control
  always_ff @(posedge clk) begin
    if (rst) begin
      status <= '0;
      step   <= '0;
    end else begin
      status.done <= 1'b0;
      if (start) begin
        status.busy <= 1'b1;
        step        <= '0;
      end else if (status.busy) begin
        step <= step + 1'b1;
        if (step == STEP_W'(NUM_W - 1)) begin
          status.busy <= 1'b0;
          status.done <= 1'b1;
        end
      end
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    if (start) begin
      rem      <= '0;
      dvs      <= divisor;
      quotient <= dividend;
    end else if (status.busy) begin
      rem      <= take ? diff[CNT_W-1:0] : trial[CNT_W-1:0];
      quotient <= {quotient[NUM_W-2:0], take};
    end
  end

endmodule
`default_nettype wire

[hw/rtl/sliding_window_loss_rate.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// sliding_window_loss_rate
// Probe loss percentage over a sliding window of outcomes, with latest RTT.
// ----------------------------------------------------------------------------
//  channel   dir  fields (lowest bit first)
//  s_axis    in   tuser: func; tdata: probe_ok, rtt_ms
//  m_axis    out  tdata: loss_pct_q8, last_rtt_ms, sample_count, fail_count
//
//  The window updates on the accepting edge; the sequencer then loads the
//  divider, the fail-by-count restoring divider works out the quotient bit
//  by bit, and the result goes into the output register. A new item is
//  taken only once the result has left the sequencer, which happens as soon
//  as the output register is free.
//  Reset is synchronous; ring contents are not cleared, counts are.
//  A result waits in the output register; a stalled output holds the next
//  result in the sequencer until the register frees.
// ----------------------------------------------------------------------------
module sliding_window_loss_rate
  import swlr_pkg::*;
(
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                s_tvalid,
  output logic                     s_tready,
  input  wire logic [S_DATA_W-1:0] s_tdata,   // probe_ok, rtt_ms, zero pad
  input  wire logic                s_tuser,   // func
  output logic                     m_tvalid,
  input  wire logic                m_tready,
  output logic      [M_DATA_W-1:0] m_tdata    // loss_pct_q8, last_rtt_ms,
                                              // sample_count, fail_count, pad
);

  seq_state_t       state;
  seq_state_t       state_next;
  logic             accept;
  logic             out_free;
  logic             div_start;
  div_status_t      div_stat;
  logic [NUM_W-1:0] quotient;
  logic [NUM_W-1:0] dividend;
  logic [CNT_W-1:0] samples;
  logic [CNT_W-1:0] fails;
  logic [RTT_W-1:0] latest_rtt;
  logic [LOSS_W-1:0] loss;
  logic [31:0]      samples_wide;
  logic [31:0]      fails_wide;

  assign s_tready  = (state == S_IDLE);
  assign accept    = s_tvalid && s_tready;
  assign out_free  = !m_tvalid || m_tready;
  assign div_start = (state == S_LOAD);

  // window state
  swlr_window u_window (
    .clk        (clk),
    .rst        (rst),
    .accept     (accept),
    .func       (s_tuser),
    .probe_ok   (s_tdata[0]),
    .rtt_ms     (s_tdata[RTT_W:1]),
    .samples    (samples),
    .fails      (fails),
    .latest_rtt (latest_rtt)
  );

  // scaled failure count
  assign dividend = NUM_W'(fails) * NUM_W'(LOSS_SCALE);

  // shared divider
  swlr_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (dividend),
    .divisor  (samples),
    .status   (div_stat),
    .quotient (quotient)
  );

  // sequencer
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: if (accept) state_next = S_LOAD;
      S_LOAD: state_next = S_DIV;
      S_DIV: begin
        if (div_stat.done) state_next = out_free ? S_IDLE : S_HOLD;
      end
      S_HOLD: if (out_free) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // loss, zero for an empty window
  assign loss = (samples == '0) ? '0 : quotient[LOSS_W-1:0];

  assign samples_wide = 32'(samples);
  assign fails_wide   = 32'(fails);

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (((state == S_DIV) && div_stat.done && out_free) ||
                 ((state == S_HOLD) && out_free)) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (((state == S_DIV) && div_stat.done && out_free) ||
        ((state == S_HOLD) && out_free)) begin
      m_tdata <= {1'b0, fails_wide[CNT_OUT_W-1:0], samples_wide[CNT_OUT_W-1:0],
                  latest_rtt, loss};
    end
  end

`ifndef NO_ASSERTIONS
  // window counts stay consistent
  a_fails_le_samples: assert property (@(posedge clk) disable iff (rst)
    fails <= samples)
    else $error("fail count above sample count");

  a_samples_le_window: assert property (@(posedge clk) disable iff (rst)
    samples <= CNT_W'(WINDOW))
    else $error("sample count above window");

  // divider idle whenever a new item may enter
  a_ready_div_idle: assert property (@(posedge clk) disable iff (rst)
    s_tready |-> !div_stat.busy)
    else $error("item accepted while divider busy");

  // every accepted item starts a division next cycle
  a_accept_load: assert property (@(posedge clk) disable iff (rst)
    accept |=> (state == S_LOAD))
    else $error("accepted item did not reach divider load");

  // loss never exceeds one hundred percent
  a_loss_range: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tdata[LOSS_W-1:0] <= LOSS_W'(LOSS_SCALE)))
    else $error("loss above one hundred percent");
`endif

endmodule
`default_nettype wire

[dv/testbench.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for sliding_window_loss_rate. Probe outcomes and clears
// go in over the slave stream, and a model of the outcome window predicts
// every result, which is checked field by field on the master stream.
// Both ends idle at random, and the output is stalled for long stretches.
// ----------------------------------------------------------------------------
module testbench;
  import swlr_pkg::*;

  // 100 percent in q8
  localparam int FULL_LOSS_Q8 = 100 * 256;
  localparam int RANDOM_ITEMS = 1700;

  typedef struct packed {
    logic [5:0]  fails;
    logic [5:0]  samples;
    logic [11:0] rtt;
    logic [14:0] loss;
  } window_report_t;

  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic                s_tvalid = 1'b0;
  logic                s_tready;
  logic [S_DATA_W-1:0] s_tdata = '0;   // probe_ok, rtt_ms, zero pad
  logic                s_tuser = 1'b0; // func
  logic                m_tvalid;
  logic                m_tready = 1'b0;
  logic [M_DATA_W-1:0] m_tdata;        // loss_pct_q8, last_rtt_ms,
                                       // sample_count, fail_count, pad

  // window model state
  logic [WINDOW-1:0] ring_bits = '0;
  int                next_slot = 0;
  int                held_samples = 0;
  int                held_fails = 0;
  logic [11:0]       held_rtt = '0;

  window_report_t pending_reports[$];
  int             mismatches = 0;
  int             items_sent = 0;
  bit             tx_steady = 1'b0;
  bit             rx_steady = 1'b0;
  int             rx_hold_req = 0;

  sliding_window_loss_rate uut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  initial begin
    forever #6 clk = ~clk;
  end

  // watchdog
  initial begin
    #20000000;
    $display("FAILURE");
    $finish;
  end

  // mostly short gaps, a few long ones
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // advance the window by one item and give the report it should produce
  function automatic window_report_t advance_window(input logic fn, input logic ok,
                                                    input logic [11:0] rtt);
    window_report_t rep;
    if (fn == FUNC_CLEAR) begin
      held_samples = 0;
      held_fails = 0;
      next_slot = 0;
    end else begin
      // the outcome leaving a full window no longer counts
      if (held_samples >= WINDOW && ring_bits[next_slot] == 1'b0 && held_fails > 0)
        held_fails--;
      ring_bits[next_slot] = ok;
      if (!ok) held_fails++;
      next_slot = (next_slot + 1) % WINDOW;
      if (held_samples < WINDOW) held_samples++;
      if (ok) held_rtt = rtt;
    end
    rep.loss    = (held_samples == 0) ? 15'd0 :
                  15'((held_fails * FULL_LOSS_Q8) / held_samples);
    rep.rtt     = held_rtt;
    rep.samples = 6'(held_samples);
    rep.fails   = 6'(held_fails);
    return rep;
  endfunction

  // offer one item and wait until it is taken
  task automatic send_probe(input logic fn, input logic ok, input logic [11:0] rtt);
    int gap;
    gap = tx_steady ? 0 : pick_gap();
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= fn;
    s_tdata  <= {3'b000, rtt, ok};
    do @(posedge clk); while (!s_tready);
    pending_reports.push_back(advance_window(fn, ok, rtt));
    items_sent++;
  endtask

  task automatic wait_for_drain();
    s_tvalid <= 1'b0;
    while (pending_reports.size() != 0) @(posedge clk);
  endtask

  // result side: check each item, then pick the next ready level
  initial begin
    int hold_left;
    int gap_left;
    window_report_t want;
    window_report_t got;
    hold_left = 0;
    gap_left = 0;
    forever begin
      @(posedge clk);
      if (!rst && m_tvalid && m_tready) begin
        got = window_report_t'(m_tdata[38:0]);
        if (pending_reports.size() == 0) begin
          mismatches++;
          $display("%0t: unexpected result %h", $time, m_tdata);
        end else begin
          want = pending_reports.pop_front();
          if (got.loss !== want.loss) begin
            mismatches++;
            $display("%0t: loss_pct_q8 expected %0d actual %0d", $time, want.loss, got.loss);
          end
          if (got.rtt !== want.rtt) begin
            mismatches++;
            $display("%0t: last_rtt_ms expected %0d actual %0d", $time, want.rtt, got.rtt);
          end
          if (got.samples !== want.samples) begin
            mismatches++;
            $display("%0t: sample_count expected %0d actual %0d", $time, want.samples,
                     got.samples);
          end
          if (got.fails !== want.fails) begin
            mismatches++;
            $display("%0t: fail_count expected %0d actual %0d", $time, want.fails, got.fails);
          end
        end
      end
      if (hold_left > 0) begin
        hold_left--;
        m_tready <= 1'b0;
      end else if (rx_hold_req > 0) begin
        hold_left = rx_hold_req - 1;
        rx_hold_req = 0;
        m_tready <= 1'b0;
      end else if (gap_left > 0) begin
        gap_left--;
        m_tready <= 1'b0;
      end else begin
        m_tready <= 1'b1;
        gap_left = rx_steady ? 0 : pick_gap();
      end
    end
  end

  // clear straight after reset, and failed probes that must not touch the rtt
  task automatic test_clear_after_reset();
    send_probe(FUNC_CLEAR, 1'b1, 12'hfff);
    send_probe(FUNC_RECORD, 1'b0, 12'hfff);
    send_probe(FUNC_RECORD, 1'b0, 12'h000);
  endtask

  // rtt at both ends and with alternating bits, mixed with failures
  task automatic test_rtt_extremes();
    send_probe(FUNC_RECORD, 1'b1, 12'hfff);
    send_probe(FUNC_RECORD, 1'b1, 12'h000);
    send_probe(FUNC_RECORD, 1'b1, 12'haaa);
    send_probe(FUNC_RECORD, 1'b0, 12'h555);
    send_probe(FUNC_RECORD, 1'b1, 12'h555);
    send_probe(FUNC_RECORD, 1'b0, 12'haaa);
  endtask

  // clear keeps the rtt, and the window restarts from empty
  task automatic test_clear_keeps_rtt();
    send_probe(FUNC_RECORD, 1'b1, 12'h123);
    send_probe(FUNC_CLEAR, 1'b0, 12'h000);
    send_probe(FUNC_CLEAR, 1'b1, 12'h7ff);
    send_probe(FUNC_RECORD, 1'b1, 12'h800);
    send_probe(FUNC_RECORD, 1'b0, 12'h001);
    wait_for_drain();
  endtask

  // output held off long enough for the block to fill and stall its input
  task automatic test_back_pressure();
    tx_steady = 1'b1;
    rx_hold_req = 400;
    repeat (12) send_probe(FUNC_RECORD, 1'($urandom_range(0, 1)), 12'($urandom));
    wait_for_drain();
    tx_steady = 1'b0;
  endtask

  // runs of outcomes, many long enough to wrap the window, each ended by a clear
  task automatic test_random_windows();
    int run_len;
    int fail_pct;
    int r;
    logic ok;
    while (items_sent < RANDOM_ITEMS) begin
      r = $urandom_range(0, 99);
      if (r < 60) run_len = $urandom_range(1, 40);
      else if (r < 90) run_len = $urandom_range(41, 100);
      else run_len = $urandom_range(101, 160);
      r = $urandom_range(0, 9);
      if (r == 0) fail_pct = 0;
      else if (r == 1) fail_pct = 100;
      else fail_pct = $urandom_range(0, 100);
      tx_steady = ($urandom_range(0, 3) == 0);
      rx_steady = ($urandom_range(0, 3) == 0);
      repeat (run_len) begin
        // a stray clear now and then
        if ($urandom_range(0, 199) == 0) begin
          send_probe(FUNC_CLEAR, 1'($urandom_range(0, 1)), 12'($urandom));
        end else begin
          ok = ($urandom_range(1, 100) > fail_pct);
          send_probe(FUNC_RECORD, ok, 12'($urandom));
        end
      end
      send_probe(FUNC_CLEAR, 1'($urandom_range(0, 1)), 12'($urandom));
      if ($urandom_range(0, 7) == 0) wait_for_drain();
    end
    tx_steady = 1'b0;
    rx_steady = 1'b0;
  endtask

  // sequence of tests
  initial begin
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_clear_after_reset();
    test_rtt_extremes();
    test_clear_keeps_rtt();
    test_back_pressure();
    test_random_windows();
    wait_for_drain();
    repeat (60) @(posedge clk);
    if (mismatches == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
`default_nettype wire
